@@ hdl/cssu_pkg.sv @@
`default_nettype none

package cssu_pkg;

   localparam int OP_W  = 3;
   localparam int ERR_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_START   = 3'd0,
      OP_ADVANCE = 3'd1,
      OP_INSERT  = 3'd2,
      OP_ATTACH  = 3'd3,
      OP_REMOVE  = 3'd4
   } op_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE       = 2'd0,
      ERR_NO_CURRENT = 2'd1,
      ERR_FULL       = 2'd2
   } err_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP,
      ST_RD_NEXT,
      ST_WR_PREV,
      ST_WR_NEW,
      ST_ADV,
      ST_RM_LINK,
      ST_RM_PREV,
      ST_LOAD,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_ACCEPT,
      ACT_START,
      ACT_RD_LINK,
      ACT_ADV_STEP,
      ACT_TAKE_FREE,
      ACT_TAKE_NEW,
      ACT_POP_FREE,
      ACT_WR_PREV,
      ACT_WR_NEW,
      ACT_RM_LINK,
      ACT_RM_PREV,
      ACT_LOAD_VAL,
      ACT_SET_ERR,
      ACT_RESPOND
   } act_type;

   typedef struct packed {
      act_type act;
      err_type err;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            cursor_ok;
      logic            before_ok;
      logic            last_ok;
      logic            full;
      logic            free_ok;
      logic            fresh_ok;
      logic            rsp_free;
   } stat_type;

endpackage

`default_nettype wire

@@ hdl/cssu_req_if.sv @@
`default_nettype none

interface cssu_req_if import cssu_pkg::*; #(
   parameter int DATA_WIDTH = 32
) ();
   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       operation;
   logic [DATA_WIDTH-1:0] entry_value;

   modport source (output valid, output operation, output entry_value, input ready);
   modport sink (input valid, input operation, input entry_value, output ready);
endinterface

`default_nettype wire

@@ hdl/cssu_rsp_if.sv @@
`default_nettype none

interface cssu_rsp_if import cssu_pkg::*; #(
   parameter int DATA_WIDTH  = 32,
   parameter int COUNT_WIDTH = 7
) ();
   logic                   valid;
   logic                   ready;
   logic                   has_current;
   logic [DATA_WIDTH-1:0]  current_value;
   logic [COUNT_WIDTH-1:0] item_count;
   logic [ERR_W-1:0]       error_code;

   modport source (output valid, output has_current, output current_value,
                   output item_count, output error_code, input ready);
   modport sink (input valid, input has_current, input current_value,
                 input item_count, input error_code, output ready);
endinterface

`default_nettype wire

@@ hdl/cursor_sequence_store_unit.sv @@
// Each transaction passes through the control states, and its result is then registered at the output;
// errors and undefined codes take the shortest path, and attach takes the longest.
// Transactions are taken one at a time; the link store has a single port.
// A new transaction is accepted while the previous result still waits at the output.
// Reset synchronously clears the list pointers and counts; the value and link stores are not cleared.
`default_nettype none

module cursor_sequence_store_unit import cssu_pkg::*; #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   cssu_req_if.sink   req_channel,
   cssu_rsp_if.source rsp_channel
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   cmd_type  cmd;
   stat_type stat;

   cssu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cssu_dpath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_channel.operation),
      .req_entry_value   (req_channel.entry_value),
      .rsp_valid         (rsp_channel.valid),
      .rsp_ready         (rsp_channel.ready),
      .rsp_has_current   (rsp_channel.has_current),
      .rsp_current_value (rsp_channel.current_value),
      .rsp_item_count    (rsp_channel.item_count),
      .rsp_error_code    (rsp_channel.error_code)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_channel.valid && req_channel.ready) |=> !req_channel.ready)
      else $error("second transaction accepted while one is in progress");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_channel.valid |-> (rsp_channel.item_count <= CNT_W'(CAPACITY)))
      else $error("item count above capacity");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_channel.valid && (rsp_channel.error_code == ERR_FULL))
      |-> (rsp_channel.item_count == CNT_W'(CAPACITY)))
      else $error("store full reported below capacity");

   a_no_current: assert property (@(posedge clock) disable iff (reset)
      (rsp_channel.valid && (rsp_channel.error_code == ERR_NO_CURRENT))
      |-> !rsp_channel.has_current)
      else $error("missing cursor reported with a current item");

endmodule

`default_nettype wire

@@ hdl/cssu_ctrl.sv @@
`default_nettype none

module cssu_ctrl import cssu_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   function automatic state_type after_take(input stat_type s);
      state_type nxt;
      nxt = ST_WR_NEW;
      if (op_type'(s.op) == OP_ATTACH) begin
         if (s.cursor_ok) begin
            nxt = ST_RD_NEXT;
         end else if (s.last_ok) begin
            nxt = ST_WR_PREV;
         end
      end else if (s.cursor_ok && s.before_ok) begin
         nxt = ST_WR_PREV;
      end
      return nxt;
   endfunction

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (op_type'(stat.op))
               OP_START: state_in = ST_LOAD;
               OP_ADVANCE: state_in = stat.cursor_ok ? ST_ADV : ST_DONE;
               OP_INSERT, OP_ATTACH: begin
                  if (stat.full) begin
                     state_in = ST_DONE;
                  end else if (stat.free_ok) begin
                     state_in = ST_POP;
                  end else if (stat.fresh_ok) begin
                     state_in = after_take(stat);
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               OP_REMOVE: state_in = stat.cursor_ok ? ST_RM_LINK : ST_DONE;
               default: state_in = ST_DONE;
            endcase
         end
         ST_POP:     state_in = after_take(stat);
         ST_RD_NEXT: state_in = ST_WR_PREV;
         ST_WR_PREV: state_in = ST_WR_NEW;
         ST_WR_NEW:  state_in = ST_DONE;
         ST_ADV:     state_in = ST_LOAD;
         ST_RM_LINK: state_in = ST_RM_PREV;
         ST_RM_PREV: state_in = ST_LOAD;
         ST_LOAD:    state_in = ST_DONE;
         ST_DONE: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.act   = ACT_NONE;
      cmd.err   = ERR_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.act = ACT_ACCEPT;
         end
         ST_EXEC: begin
            case (op_type'(stat.op))
               OP_START: cmd.act = ACT_START;
               OP_ADVANCE, OP_REMOVE: begin
                  if (stat.cursor_ok) begin
                     cmd.act = ACT_RD_LINK;
                  end else begin
                     cmd.act = ACT_SET_ERR;
                     cmd.err = ERR_NO_CURRENT;
                  end
               end
               OP_INSERT, OP_ATTACH: begin
                  if (stat.full) begin
                     cmd.act = ACT_SET_ERR;
                     cmd.err = ERR_FULL;
                  end else if (stat.free_ok) begin
                     cmd.act = ACT_TAKE_FREE;
                  end else if (stat.fresh_ok) begin
                     cmd.act = ACT_TAKE_NEW;
                  end else begin
                     cmd.act = ACT_SET_ERR;
                     cmd.err = ERR_FULL;
                  end
               end
               default: cmd.act = ACT_NONE;
            endcase
         end
         ST_POP:     cmd.act = ACT_POP_FREE;
         ST_RD_NEXT: cmd.act = ACT_RD_LINK;
         ST_WR_PREV: cmd.act = ACT_WR_PREV;
         ST_WR_NEW:  cmd.act = ACT_WR_NEW;
         ST_ADV:     cmd.act = ACT_ADV_STEP;
         ST_RM_LINK: cmd.act = ACT_RM_LINK;
         ST_RM_PREV: cmd.act = ACT_RM_PREV;
         ST_LOAD:    cmd.act = ACT_LOAD_VAL;
         ST_DONE: begin
            if (stat.rsp_free) cmd.act = ACT_RESPOND;
         end
         default: cmd.act = ACT_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/cssu_dpath.sv @@
`default_nettype none

module cssu_dpath import cssu_pkg::*; #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire cmd_type                           cmd,
   output stat_type                               stat,
   input  wire logic [OP_W-1:0]                   req_operation,
   input  wire logic [DATA_WIDTH-1:0]             req_entry_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_has_current,
   output logic [DATA_WIDTH-1:0]                  rsp_current_value,
   output logic [$clog2(CAPACITY+1)-1:0]          rsp_item_count,
   output logic [ERR_W-1:0]                       rsp_error_code
);

   localparam int PTR_W = $clog2(CAPACITY + 1);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CAPACITY);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   logic [DATA_WIDTH-1:0] val_mem [CAPACITY];
   logic [PTR_W-1:0]      link_mem [CAPACITY];
   logic [DATA_WIDTH-1:0] val_rd_ff;
   logic [PTR_W-1:0]      link_rd_ff;

   logic                  val_we, val_re, link_we, link_re;
   logic [IDX_W-1:0]      val_addr, link_addr;
   logic [DATA_WIDTH-1:0] val_wdata;
   logic [PTR_W-1:0]      link_wdata;

   logic [OP_W-1:0]       op_ff, op_in;
   logic [DATA_WIDTH-1:0] entry_ff, entry_in;
   err_type               err_ff, err_in;
   logic [PTR_W-1:0]      first_ff, first_in;
   logic [PTR_W-1:0]      last_ff, last_in;
   logic [PTR_W-1:0]      cursor_ff, cursor_in;
   logic [PTR_W-1:0]      before_ff, before_in;
   logic [PTR_W-1:0]      free_ff, free_in;
   logic [PTR_W-1:0]      slot_ff, slot_in;
   logic [PTR_W-1:0]      nxt_ff, nxt_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      fresh_ff, fresh_in;
   logic [DATA_WIDTH-1:0] curval_ff, curval_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_has_ff, rsp_has_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   err_type               rsp_err_ff, rsp_err_in;

   logic first_ok, last_ok, cursor_ok, before_ok, free_ok, is_insert;

   function automatic logic ptr_ok(input logic [PTR_W-1:0] p);
      return p < NULL_PTR;
   endfunction

   function automatic logic [IDX_W-1:0] idx(input logic [PTR_W-1:0] p);
      return p[IDX_W-1:0];
   endfunction

   assign first_ok  = ptr_ok(first_ff);
   assign last_ok   = ptr_ok(last_ff);
   assign cursor_ok = ptr_ok(cursor_ff);
   assign before_ok = ptr_ok(before_ff);
   assign free_ok   = ptr_ok(free_ff);
   assign is_insert = (op_type'(op_ff) == OP_INSERT);

   assign stat.op        = op_ff;
   assign stat.cursor_ok = cursor_ok;
   assign stat.before_ok = before_ok;
   assign stat.last_ok   = last_ok;
   assign stat.full      = (count_ff >= FULL_CNT);
   assign stat.free_ok   = free_ok;
   assign stat.fresh_ok  = (fresh_ff < FULL_CNT);
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      op_in        = op_ff;
      entry_in     = entry_ff;
      err_in       = err_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      cursor_in    = cursor_ff;
      before_in    = before_ff;
      free_in      = free_ff;
      slot_in      = slot_ff;
      nxt_in       = nxt_ff;
      count_in     = count_ff;
      fresh_in     = fresh_ff;
      curval_in    = curval_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_has_in   = rsp_has_ff;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      rsp_err_in   = rsp_err_ff;
      val_we       = 1'b0;
      val_re       = 1'b0;
      val_addr     = idx(slot_ff);
      val_wdata    = entry_ff;
      link_we      = 1'b0;
      link_re      = 1'b0;
      link_addr    = idx(cursor_ff);
      link_wdata   = NULL_PTR;

      case (cmd.act)
         ACT_ACCEPT: begin
            op_in    = req_operation;
            entry_in = req_entry_value;
            err_in   = ERR_NONE;
         end
         ACT_SET_ERR: begin
            err_in = cmd.err;
         end
         ACT_START: begin
            cursor_in = first_ok ? first_ff : NULL_PTR;
            before_in = NULL_PTR;
            val_re    = first_ok;
            val_addr  = idx(first_ff);
         end
         ACT_RD_LINK: begin
            link_re   = 1'b1;
            link_addr = idx(cursor_ff);
         end
         ACT_ADV_STEP: begin
            if (ptr_ok(link_rd_ff)) begin
               cursor_in = link_rd_ff;
               before_in = cursor_ff;
               val_re    = 1'b1;
               val_addr  = idx(link_rd_ff);
            end else begin
               cursor_in = NULL_PTR;
               before_in = NULL_PTR;
            end
         end
         ACT_TAKE_FREE: begin
            slot_in   = free_ff;
            link_re   = 1'b1;
            link_addr = idx(free_ff);
         end
         ACT_TAKE_NEW: begin
            slot_in  = PTR_W'(fresh_ff);
            fresh_in = fresh_ff + 1'b1;
         end
         ACT_POP_FREE: begin
            free_in = link_rd_ff;
         end
         ACT_WR_PREV: begin
            link_we    = 1'b1;
            link_wdata = slot_ff;
            if (is_insert) begin
               link_addr = idx(before_ff);
            end else if (cursor_ok) begin
               link_addr = idx(cursor_ff);
            end else begin
               link_addr = idx(last_ff);
            end
         end
         ACT_WR_NEW: begin
            val_we    = 1'b1;
            val_addr  = idx(slot_ff);
            link_we   = 1'b1;
            link_addr = idx(slot_ff);
            if (is_insert) begin
               if (cursor_ok && before_ok) begin
                  link_wdata = cursor_ff;
               end else begin
                  link_wdata = first_ok ? first_ff : NULL_PTR;
                  first_in   = slot_ff;
                  if (!last_ok) last_in = slot_ff;
                  before_in  = NULL_PTR;
               end
            end else if (cursor_ok) begin
               link_wdata = link_rd_ff;
               if (last_ff == cursor_ff) last_in = slot_ff;
               before_in  = cursor_ff;
            end else begin
               link_wdata = NULL_PTR;
               if (!last_ok) first_in = slot_ff;
               before_in  = last_ok ? last_ff : NULL_PTR;
               last_in    = slot_ff;
            end
            cursor_in = slot_ff;
            count_in  = count_ff + 1'b1;
            curval_in = entry_ff;
         end
         ACT_RM_LINK: begin
            nxt_in     = ptr_ok(link_rd_ff) ? link_rd_ff : NULL_PTR;
            link_we    = 1'b1;
            link_addr  = idx(cursor_ff);
            link_wdata = free_ff;
            free_in    = cursor_ff;
         end
         ACT_RM_PREV: begin
            if (before_ok) begin
               link_we    = 1'b1;
               link_addr  = idx(before_ff);
               link_wdata = nxt_ff;
            end else begin
               first_in = nxt_ff;
            end
            if (last_ff == cursor_ff) last_in = before_ok ? before_ff : NULL_PTR;
            cursor_in = nxt_ff;
            if (!ptr_ok(nxt_ff)) before_in = NULL_PTR;
            if (count_ff != '0) count_in = count_ff - 1'b1;
            val_re   = ptr_ok(nxt_ff);
            val_addr = idx(nxt_ff);
         end
         ACT_LOAD_VAL: begin
            if (cursor_ok) curval_in = val_rd_ff;
         end
         ACT_RESPOND: begin
            rsp_valid_in = 1'b1;
            rsp_has_in   = cursor_ok;
            rsp_value_in = cursor_ok ? curval_ff : '0;
            rsp_count_in = count_ff;
            rsp_err_in   = err_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_addr] <= val_wdata;
      end else if (val_re) begin
         val_rd_ff <= val_mem[val_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_addr] <= link_wdata;
      end else if (link_re) begin
         link_rd_ff <= link_mem[link_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= NULL_PTR;
         last_ff      <= NULL_PTR;
         cursor_ff    <= NULL_PTR;
         before_ff    <= NULL_PTR;
         free_ff      <= NULL_PTR;
         count_ff     <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         first_ff     <= first_in;
         last_ff      <= last_in;
         cursor_ff    <= cursor_in;
         before_ff    <= before_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      entry_ff     <= entry_in;
      err_ff       <= err_in;
      slot_ff      <= slot_in;
      nxt_ff       <= nxt_in;
      curval_ff    <= curval_in;
      rsp_has_ff   <= rsp_has_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_has_current   = rsp_has_ff;
   assign rsp_current_value = rsp_value_ff;
   assign rsp_item_count    = rsp_count_ff;
   assign rsp_error_code    = rsp_err_ff;

endmodule

`default_nettype wire

@@ tb/cursor_sequence_store_unit_checker.sv @@
`timescale 1ns / 100ps

module cursor_sequence_store_unit_checker import cssu_pkg::*; #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   cssu_req_if         req_mon,
   cssu_rsp_if         rsp_mon,
   output int unsigned fail_count,
   output int unsigned reports_pending,
   output int unsigned reports_seen,
   output int unsigned full_reports,
   output int unsigned no_current_reports
);

   localparam int SLOT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(CAPACITY);

   typedef struct packed {
      logic                  has_current;
      logic [DATA_WIDTH-1:0] current_value;
      logic [SLOT_W-1:0]     item_count;
      logic [ERR_W-1:0]      error_code;
   } seq_report_type;

   logic [DATA_WIDTH-1:0] slot_value [CAPACITY];
   logic [SLOT_W-1:0]     slot_link  [CAPACITY];
   logic [SLOT_W-1:0]     head_slot;
   logic [SLOT_W-1:0]     tail_slot;
   logic [SLOT_W-1:0]     cur_slot;
   logic [SLOT_W-1:0]     prev_slot;
   logic [SLOT_W-1:0]     free_head;
   logic [SLOT_W-1:0]     fresh_slots;
   logic [SLOT_W-1:0]     held_items;

   seq_report_type pending_reports [$];
   seq_report_type want;
   seq_report_type got;
   int unsigned fails;
   int unsigned seen;
   int unsigned full_seen;
   int unsigned no_cur_seen;

   function automatic logic is_slot(input logic [SLOT_W-1:0] s);
      return s < CAPACITY;
   endfunction

   function automatic logic [IDX_W-1:0] slot_idx(input logic [SLOT_W-1:0] s);
      return s[IDX_W-1:0];
   endfunction

   task automatic apply_sequence_op(input logic [OP_W-1:0] op,
                                    input logic [DATA_WIDTH-1:0] value,
                                    output seq_report_type rpt);
      logic [SLOT_W-1:0] s;
      logic [SLOT_W-1:0] nxt;
      logic [ERR_W-1:0]  err;
      err = ERR_NONE;
      case (op)
         OP_START: begin
            cur_slot  = is_slot(head_slot) ? head_slot : NO_SLOT;
            prev_slot = NO_SLOT;
         end
         OP_ADVANCE: begin
            if (!is_slot(cur_slot)) begin
               err = ERR_NO_CURRENT;
            end else begin
               prev_slot = cur_slot;
               cur_slot  = slot_link[slot_idx(cur_slot)];
               if (!is_slot(cur_slot)) begin
                  cur_slot  = NO_SLOT;
                  prev_slot = NO_SLOT;
               end
            end
         end
         OP_INSERT, OP_ATTACH: begin
            if (held_items >= CAPACITY) begin
               err = ERR_FULL;
            end else begin
               if (is_slot(free_head)) begin
                  s         = free_head;
                  free_head = slot_link[slot_idx(s)];
               end else begin
                  s           = fresh_slots;
                  fresh_slots = fresh_slots + 1'b1;
               end
               slot_value[slot_idx(s)] = value;
               if (op == OP_INSERT) begin
                  if (!is_slot(cur_slot) || !is_slot(prev_slot)) begin
                     slot_link[slot_idx(s)] = is_slot(head_slot) ? head_slot : NO_SLOT;
                     head_slot    = s;
                     if (!is_slot(tail_slot)) tail_slot = s;
                     prev_slot = NO_SLOT;
                  end else begin
                     slot_link[slot_idx(s)]         = cur_slot;
                     slot_link[slot_idx(prev_slot)] = s;
                  end
               end else begin
                  if (!is_slot(cur_slot)) begin
                     slot_link[slot_idx(s)] = NO_SLOT;
                     if (is_slot(tail_slot)) slot_link[slot_idx(tail_slot)] = s;
                     else head_slot = s;
                     prev_slot = is_slot(tail_slot) ? tail_slot : NO_SLOT;
                     tail_slot = s;
                  end else begin
                     slot_link[slot_idx(s)]        = slot_link[slot_idx(cur_slot)];
                     slot_link[slot_idx(cur_slot)] = s;
                     if (tail_slot == cur_slot) tail_slot = s;
                     prev_slot = cur_slot;
                  end
               end
               cur_slot   = s;
               held_items = held_items + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (!is_slot(cur_slot)) begin
               err = ERR_NO_CURRENT;
            end else begin
               nxt = slot_link[slot_idx(cur_slot)];
               if (!is_slot(nxt)) nxt = NO_SLOT;
               if (is_slot(prev_slot)) slot_link[slot_idx(prev_slot)] = nxt;
               else head_slot = nxt;
               if (tail_slot == cur_slot) tail_slot = is_slot(prev_slot) ? prev_slot : NO_SLOT;
               slot_link[slot_idx(cur_slot)] = free_head;
               free_head           = cur_slot;
               cur_slot            = nxt;
               if (!is_slot(cur_slot)) prev_slot = NO_SLOT;
               if (held_items > 0) held_items = held_items - 1'b1;
            end
         end
         default: begin
         end
      endcase
      rpt.has_current   = is_slot(cur_slot);
      rpt.current_value = is_slot(cur_slot) ? slot_value[slot_idx(cur_slot)] : '0;
      rpt.item_count    = held_items;
      rpt.error_code    = err;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         head_slot   = NO_SLOT;
         tail_slot   = NO_SLOT;
         cur_slot    = NO_SLOT;
         prev_slot   = NO_SLOT;
         free_head   = NO_SLOT;
         fresh_slots = '0;
         held_items  = '0;
         pending_reports.delete();
         fails       = 0;
         seen        = 0;
         full_seen   = 0;
         no_cur_seen = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            apply_sequence_op(req_mon.operation, req_mon.entry_value, want);
            pending_reports.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.has_current   = rsp_mon.has_current;
            got.current_value = rsp_mon.current_value;
            got.item_count    = rsp_mon.item_count;
            got.error_code    = rsp_mon.error_code;
            seen++;
            if (got.error_code == ERR_FULL) full_seen++;
            if (got.error_code == ERR_NO_CURRENT) no_cur_seen++;
            if (pending_reports.size() == 0) begin
               $display("%0t: unexpected report cur=%0b val=%h count=%0d err=%0d", $time,
                        got.has_current, got.current_value, got.item_count, got.error_code);
               fails++;
            end else begin
               want = pending_reports.pop_front();
               if (got.has_current !== want.has_current ||
                   got.current_value !== want.current_value ||
                   got.item_count !== want.item_count ||
                   got.error_code !== want.error_code) begin
                  $display("%0t: report mismatch, expected cur=%0b val=%h count=%0d err=%0d",
                           $time, want.has_current, want.current_value, want.item_count,
                           want.error_code);
                  $display("%0t:                  actual cur=%0b val=%h count=%0d err=%0d",
                           $time, got.has_current, got.current_value, got.item_count,
                           got.error_code);
                  fails++;
               end
            end
         end
      end
      fail_count         <= fails;
      reports_pending    <= pending_reports.size();
      reports_seen       <= seen;
      full_reports       <= full_seen;
      no_current_reports <= no_cur_seen;
   end

endmodule

@@ tb/cursor_sequence_store_unit_tb.sv @@
`timescale 1ns / 100ps

module cursor_sequence_store_unit_tb;
   import cssu_pkg::*;

   localparam int CAPACITY       = 64;
   localparam int DATA_WIDTH     = 32;
   localparam int COUNT_W        = $clog2(CAPACITY + 1);
   localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;
   localparam int ITEM_TARGET    = 1050;
   localparam int FILL_POINT     = 400;
   localparam int FILL_OPS       = CAPACITY + 8;
   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} op_mix_type;

   logic        clock;
   logic        reset;
   bit          no_idle;
   int unsigned ops_applied;
   int unsigned idle_cycles;
   int unsigned fail_count;
   int unsigned reports_pending;
   int unsigned reports_seen;
   int unsigned full_reports;
   int unsigned no_current_reports;

   cssu_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_ch ();
   cssu_rsp_if #(.DATA_WIDTH(DATA_WIDTH), .COUNT_WIDTH(COUNT_W)) rsp_ch ();

   cursor_sequence_store_unit #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_ch),
      .rsp_channel (rsp_ch)
   );

   cursor_sequence_store_unit_checker #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_mon            (req_ch),
      .rsp_mon            (rsp_ch),
      .fail_count         (fail_count),
      .reports_pending    (reports_pending),
      .reports_seen       (reports_seen),
      .full_reports       (full_reports),
      .no_current_reports (no_current_reports)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [DATA_WIDTH-1:0] random_entry();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return DATA_WIDTH'($urandom_range(0, 255));
         default: return DATA_WIDTH'($urandom);
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input op_mix_type mix);
      int r;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_GROW: begin
            if (r < 10) return OP_START;
            if (r < 25) return OP_ADVANCE;
            if (r < 50) return OP_INSERT;
            if (r < 80) return OP_ATTACH;
            if (r < 95) return OP_REMOVE;
         end
         MIX_SHRINK: begin
            if (r < 12) return OP_START;
            if (r < 30) return OP_ADVANCE;
            if (r < 40) return OP_INSERT;
            if (r < 50) return OP_ATTACH;
            if (r < 95) return OP_REMOVE;
         end
         default: begin
            if (r < 15) return OP_START;
            if (r < 35) return OP_ADVANCE;
            if (r < 55) return OP_INSERT;
            if (r < 75) return OP_ATTACH;
            if (r < 95) return OP_REMOVE;
         end
      endcase
      return OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
   endfunction

   // Called at a rising edge; returns at the edge where the transaction is accepted.
   task automatic send_op(input logic [OP_W-1:0] op, input logic [DATA_WIDTH-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= op;
      req_ch.entry_value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (op < OP_UNDEF_LO) ops_applied++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (reports_pending != 0);
   endtask

   task automatic run_block(input op_mix_type mix, input int len);
      no_idle = ($urandom_range(0, 4) == 0);
      repeat (len) send_op(pick_op(mix), random_entry());
      no_idle = 1'b0;
   endtask

   initial begin
      int stall;
      stall         = 0;
      rsp_ch.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("cursor_sequence_store_unit_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.operation   = OP_START;
      req_ch.entry_value = '0;
      no_idle            = 1'b0;
      ops_applied        = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty sequence, then the unused codes.
      send_op(OP_ADVANCE, '0);
      send_op(OP_REMOVE, '1);
      send_op(OP_START, '0);
      send_op(3'd5, 32'hFFFF_FFFF);
      send_op(3'd6, 32'h0000_0000);
      send_op(3'd7, 32'h1357_9BDF);
      // Insert and attach with and without a current item.
      send_op(OP_INSERT, 32'h0000_0000);
      send_op(OP_ATTACH, 32'hFFFF_FFFF);
      send_op(OP_ADVANCE, '0);
      send_op(OP_ATTACH, 32'hA5A5_A5A5);
      send_op(OP_INSERT, 32'h5A5A_5A5A);
      send_op(OP_ADVANCE, '0);
      send_op(OP_ADVANCE, '0);
      send_op(OP_INSERT, 32'h1234_5678);
      send_op(OP_START, '0);
      send_op(OP_REMOVE, '0);
      send_op(OP_ADVANCE, '0);
      send_op(OP_REMOVE, '0);
      // Empty it from the front; the final remove has no current item.
      send_op(OP_START, '0);
      repeat (4) send_op(OP_REMOVE, '0);
      wait_drained();

      while (ops_applied < FILL_POINT)
         run_block(op_mix_type'($urandom_range(0, 2)), $urandom_range(5, 40));

      // Fill the store past capacity, then shrink it with a remove-heavy mix.
      wait_drained();
      send_op(OP_START, random_entry());
      repeat (FILL_OPS) send_op($urandom_range(0, 1) ? OP_INSERT : OP_ATTACH, random_entry());
      wait_drained();
      send_op(OP_START, random_entry());
      run_block(MIX_SHRINK, 90);

      while (ops_applied < ITEM_TARGET)
         run_block(op_mix_type'($urandom_range(0, 2)), $urandom_range(5, 40));

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Applied %0d sequence operations and checked %0d reports.",
               ops_applied, reports_seen);
      $display("Reports with store full: %0d, with no current item: %0d.",
               full_reports, no_current_reports);
      if (fail_count == 0) begin
         $display("cursor_sequence_store_unit_tb: done, clean");
      end else begin
         $display("cursor_sequence_store_unit_tb: done, errors");
      end
      $finish;
   end

endmodule

@@ cursor_sequence_store_unit.f @@
hdl/cssu_pkg.sv
hdl/cssu_req_if.sv
hdl/cssu_rsp_if.sv
hdl/cssu_ctrl.sv
hdl/cssu_dpath.sv
hdl/cursor_sequence_store_unit.sv
tb/cursor_sequence_store_unit_checker.sv
tb/cursor_sequence_store_unit_tb.sv
